// ===== design/factorial_trailing_zeros_base_defines.svh =====
// assertion helpers shared by the design files
`ifndef FACTORIAL_TRAILING_ZEROS_BASE_DEFINES_SVH
`define FACTORIAL_TRAILING_ZEROS_BASE_DEFINES_SVH

// property must hold on every clock edge out of reset
`define FTZ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define FTZ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ftz_pkg.sv =====
package ftz_pkg;

  localparam int unsigned NBitsDefault = 63;
  localparam int unsigned BBitsDefault = 40;

  typedef enum logic [3:0] {
    StIdle,
    StTrialChk,
    StTrialDiv,
    StTrialWait,
    StLegStart,
    StLegDiv,
    StLegWait,
    StExpDiv,
    StExpWait,
    StDone
  } ftz_state_e;

  // divider operand selection
  typedef enum logic [1:0] {
    DivRestByI,
    DivTermByP,
    DivSumByE
  } ftz_div_sel_e;

  typedef struct packed {
    logic         load;
    logic         div_start;
    ftz_div_sel_e div_sel;
    logic         trial_commit;  // rest <- quotient, e++
    logic         trial_next;    // i++
    logic         leg_init;      // term <- n, sum <- 0
    logic         leg_add;       // sum += quotient, term <- quotient
    logic         sel_last;      // prime is the leftover rest
    logic         take_min;      // fold quotient into best
    logic         clr_e;
  } ftz_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic rem_zero;
    logic i_sq_le_rest;  // i <= rest / i, i.e. i*i <= rest
    logic rest_ge2;
    logic rest_gt1;
    logic e_nonzero;
    logic p_le_term;     // next Legendre term is nonzero
  } ftz_status_t;

endpackage

// ===== design/factorial_trailing_zeros_base.sv =====
// trailing zeros of n! in base b
// input channel: factorial_arg_i (n) and radix_i (b) with in_valid_i/in_ready_o;
// output channel: zero_count_o with out_valid_o/out_ready_i.
// one item at a time: in_ready_o is high only while the block is idle.
// the base is factored by trial division with a shared bit-serial divider.
// each trial divisor costs one division plus one for each time it divides the
// base, each prime adds its Legendre terms (one division per power of p not
// above n) and one division by the exponent.
// the next item is accepted in the cycle after the result is taken.
// the result is held on zero_count_o with out_valid_o high until taken;
// a stalled receiver simply holds the block, the next item waits.
// reset returns the controller to idle with no result pending.
module factorial_trailing_zeros_base import ftz_pkg::*; #(
  parameter int unsigned N_BITS = NBitsDefault,
  parameter int unsigned B_BITS = BBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [N_BITS-1:0] factorial_arg_i,
  input  logic [B_BITS-1:0] radix_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [N_BITS-1:0] zero_count_o
);
  ftz_cmd_t    cmd;
  ftz_status_t status;

  ftz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ftz_datapath #(.NBits(N_BITS), .BBits(B_BITS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .factorial_arg_i(factorial_arg_i),
    .radix_i        (radix_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .zero_count_o   (zero_count_o)
  );
endmodule

// ===== design/ftz_divider.sv =====
module ftz_divider import ftz_pkg::*; #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W-1:0]  q_q, q_d, r_q, r_d, dv_q, dv_d;
  logic [W:0]    trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    q_d    = q_q;
    r_d    = r_q;
    dv_d   = dv_q;
    trial  = {r_q, q_q[W-1]} - {1'b0, dv_q};
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      q_d    = dividend_i;
      r_d    = '0;
      dv_d   = divisor_i;
    end else if (busy_q) begin
      if (!trial[W]) begin
        r_d = trial[W-1:0];
        q_d = {q_q[W-2:0], 1'b1};
      end else begin
        r_d = {r_q[W-2:0], q_q[W-1]};
        q_d = {q_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q  <= q_d;
    r_q  <= r_d;
    dv_q <= dv_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;
endmodule

// ===== design/ftz_datapath.sv =====
module ftz_datapath import ftz_pkg::*; #(
  parameter int unsigned NBits = NBitsDefault,
  parameter int unsigned BBits = BBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [NBits-1:0] factorial_arg_i,
  input  logic [BBits-1:0] radix_i,
  input  ftz_cmd_t         cmd_i,
  output ftz_status_t      status_o,
  output logic [NBits-1:0] zero_count_o
);
  `include "factorial_trailing_zeros_base_defines.svh"

  localparam int unsigned W  = (NBits > BBits) ? NBits : BBits;
  localparam int unsigned HB = (BBits + 1) / 2 + 1;  // trial divisor width

  logic [NBits-1:0] n_q, best_q, sum_q;
  logic [BBits-1:0] rest_q, p_q;
  logic [HB-1:0]    i_q;
  logic [BBits-1:0] e_q;
  logic [W-1:0]     term_q;
  logic             have_q;
  logic [W-1:0]     dvd, dvs, quot, rem;
  logic [2*HB-1:0]  isq;

  always_comb begin
    case (cmd_i.div_sel)
      DivRestByI: begin
        dvd = W'(rest_q);
        dvs = W'(i_q);
      end
      DivTermByP: begin
        dvd = term_q;
        dvs = W'(p_q);
      end
      DivSumByE: begin
        dvd = W'(sum_q);
        dvs = W'(e_q);
      end
      default: begin
        dvd = '0;
        dvs = '1;
      end
    endcase
  end

  ftz_divider #(.W(W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(dvd),
    .divisor_i (dvs),
    .busy_o    (status_o.div_busy),
    .done_o    (status_o.div_done),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  assign isq = (2*HB)'(i_q) * (2*HB)'(i_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (cmd_i.load) begin
      have_q <= 1'b0;
    end else if (cmd_i.take_min) begin
      have_q <= 1'b1;
    end
  end

  // floor(n/p^(k+1)) = floor(floor(n/p^k)/p), so each term comes from the one before
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q    <= factorial_arg_i;
      rest_q <= radix_i;
      i_q    <= HB'(2);
      e_q    <= '0;
      best_q <= '0;
    end
    if (cmd_i.trial_commit) begin
      rest_q <= quot[BBits-1:0];
      e_q    <= e_q + BBits'(1);
    end
    if (cmd_i.trial_next) i_q <= i_q + HB'(1);
    if (cmd_i.clr_e) e_q <= '0;
    if (cmd_i.leg_init) begin
      p_q    <= cmd_i.sel_last ? rest_q : BBits'(i_q);
      term_q <= W'(n_q);
      sum_q  <= '0;
      if (cmd_i.sel_last) e_q <= BBits'(1);
    end
    if (cmd_i.leg_add) begin
      sum_q  <= sum_q + quot[NBits-1:0];
      term_q <= quot;
    end
    if (cmd_i.take_min && (!have_q || quot[NBits-1:0] < best_q))
      best_q <= quot[NBits-1:0];
  end

  assign status_o.rem_zero     = (rem == '0);
  assign status_o.i_sq_le_rest = (isq <= (2*HB)'(rest_q));
  assign status_o.rest_ge2     = (rest_q >= BBits'(2));
  assign status_o.rest_gt1     = (rest_q > BBits'(1));
  assign status_o.e_nonzero    = (e_q != '0);
  assign status_o.p_le_term    = (W'(p_q) <= term_q);
  // best stays zero when the base has no prime factor
  assign zero_count_o          = best_q;

  `FTZ_ASSERT(a_best_le_n, !have_q || best_q <= n_q, "minimum exceeds n")
  `FTZ_ASSERT(a_i_ge2, !cmd_i.div_start || cmd_i.div_sel != DivRestByI || i_q >= HB'(2), "trial divisor below two")
  `FTZ_ASSERT(a_dvs_nz, !cmd_i.div_start || dvs != '0, "division by zero")
endmodule

// ===== design/ftz_ctrl.sv =====
module ftz_ctrl import ftz_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  ftz_status_t status_i,
  output ftz_cmd_t    cmd_o
);
  `include "factorial_trailing_zeros_base_defines.svh"

  ftz_state_e state_q, state_d;
  logic       last_q, last_d;  // working on the leftover prime

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    case (state_q)
      StIdle: if (in_valid_i) begin
        state_d = StTrialChk;
        last_d  = 1'b0;
      end
      StTrialChk: begin
        if (!status_i.rest_ge2 && !status_i.e_nonzero) state_d = StDone;
        else if (status_i.i_sq_le_rest) state_d = StTrialDiv;
        else if (status_i.rest_gt1) begin
          last_d  = 1'b1;
          state_d = StLegStart;
        end else state_d = StDone;
      end
      StTrialDiv: state_d = StTrialWait;
      StTrialWait: if (status_i.div_done) begin
        if (status_i.rem_zero) state_d = StTrialDiv;
        else if (status_i.e_nonzero) state_d = StLegStart;
        else state_d = StTrialChk;
      end
      StLegStart: state_d = StLegDiv;
      StLegDiv: state_d = status_i.p_le_term ? StLegWait : StExpDiv;
      StLegWait: if (status_i.div_done) state_d = StLegDiv;
      StExpDiv: state_d = StExpWait;
      StExpWait: if (status_i.div_done) state_d = last_q ? StDone : StTrialChk;
      StDone: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.div_sel    = DivRestByI;
    cmd_o.sel_last   = last_q;
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StTrialDiv: cmd_o.div_start = 1'b1;
      StTrialWait: if (status_i.div_done) begin
        if (status_i.rem_zero) cmd_o.trial_commit = 1'b1;
        else if (!status_i.e_nonzero) cmd_o.trial_next = 1'b1;
      end
      StLegStart: cmd_o.leg_init = 1'b1;
      StLegDiv: begin
        cmd_o.div_sel   = DivTermByP;
        cmd_o.div_start = status_i.p_le_term;
      end
      StLegWait: begin
        cmd_o.div_sel = DivTermByP;
        cmd_o.leg_add = status_i.div_done;
      end
      StExpDiv: begin
        cmd_o.div_sel   = DivSumByE;
        cmd_o.div_start = 1'b1;
      end
      StExpWait: begin
        cmd_o.div_sel = DivSumByE;
        if (status_i.div_done) begin
          cmd_o.take_min   = 1'b1;
          cmd_o.clr_e      = 1'b1;
          cmd_o.trial_next = !last_q;
        end
      end
      StDone: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  `FTZ_ASSERT(a_excl, !(in_ready_o && out_valid_o), "ready while result pending")
  `FTZ_ASSERT_NEXT(a_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `FTZ_ASSERT(a_start_idle, !cmd_o.div_start || !status_i.div_busy, "divider restarted")
endmodule
